[sv/ris_pkg.sv]
package ris_pkg;

  localparam int unsigned KeyW = 24;
  localparam int unsigned CapW = 31;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [CapW-1:0] capacity;
    logic            open_flag;
  } record_t;

  localparam int unsigned RecW = $bits(record_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_EMIT_RD,
    ST_EMIT_LOAD
  } state_e;

  // string order: bytes after the first zero byte do not count
  function automatic logic [KeyW-1:0] cmp_key(input logic [KeyW-1:0] k);
    logic [KeyW-1:0] r;
    r = k;
    if (k[23:16] == 8'h00) begin
      r = '0;
    end else if (k[15:8] == 8'h00) begin
      r = {k[23:16], 16'h0000};
    end
    return r;
  endfunction

endpackage

[sv/ris_ram.sv]
module ris_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

[sv/record_insertion_sorter_unit.sv]
// insertion: an item is taken while idle; its insertion then moves up, in the
// store, the k records with a greater key (k up to MAX_RECORDS-1), one record
// per cycle through the single read / single write port, then writes the item
// the next item is accepted once the insertion ends and, after a set-ending item,
// when all records are emitted, each read, then loaded when the output is free
// reset: asynchronous, active low; empties the store and drops the output
module record_insertion_sorter_unit #(
  parameter int unsigned MAX_RECORDS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [ris_pkg::KeyW-1:0] sort_key_i,
  input  logic [ris_pkg::CapW-1:0] payload_capacity_i,
  input  logic                  open_flag_i,
  input  logic                  end_of_set_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [ris_pkg::KeyW-1:0] sorted_key_o,
  output logic [ris_pkg::CapW-1:0] sorted_capacity_o,
  output logic                  sorted_open_o,
  output logic                  final_result_o
);

  import ris_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_RECORDS);
  localparam int unsigned CntW = $clog2(MAX_RECORDS + 1);

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] pos_q, pos_d;
  logic [IdxW-1:0] emit_idx_q, emit_idx_d;
  record_t         new_rec_q, new_rec_d;
  logic [KeyW-1:0] new_ck_q, new_ck_d;
  logic            last_q, last_d;

  logic            out_valid_q, out_valid_d;
  record_t         out_rec_q, out_rec_d;
  logic            out_final_q, out_final_d;

  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  record_t         wr_data;
  logic [IdxW-1:0] rd_addr;
  logic [RecW-1:0] rd_raw;
  record_t         rd_rec;
  logic [IdxW-1:0] pos_m1;
  logic [CntW-1:0] count_m1;
  logic            in_accept;
  logic            out_free;
  logic            greater;

  ris_ram #(
    .WIDTH(RecW),
    .DEPTH(MAX_RECORDS)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_raw)
  );

  assign rd_rec    = record_t'(rd_raw);
  assign pos_m1    = pos_q - 1'b1;
  assign count_m1  = count_q - 1'b1;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign greater   = cmp_key(rd_rec.key) > new_ck_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    emit_idx_d  = emit_idx_q;
    new_rec_d   = new_rec_q;
    new_ck_d    = new_ck_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_rec_d   = out_rec_q;
    out_final_d = out_final_q;
    wr_en       = 1'b0;
    wr_addr     = pos_q;
    wr_data     = new_rec_q;
    rd_addr     = emit_idx_q;

    case (state_q)
      ST_IDLE: begin
        rd_addr = count_m1[IdxW-1:0];
        if (in_accept) begin
          new_rec_d.key       = sort_key_i;
          new_rec_d.capacity  = payload_capacity_i;
          new_rec_d.open_flag = open_flag_i;
          new_ck_d            = cmp_key(sort_key_i);
          last_d              = end_of_set_i;
          emit_idx_d          = '0;
          if (count_q < CntW'(MAX_RECORDS)) begin
            pos_d   = count_q[IdxW-1:0];
            state_d = ST_SHIFT;
          end else if (end_of_set_i) begin
            // store full: item dropped, the set is still emitted
            state_d = ST_EMIT_RD;
          end
        end
      end

      ST_SHIFT: begin
        rd_addr = pos_m1 - 1'b1;
        if (pos_q != '0 && greater) begin
          wr_en   = 1'b1;
          wr_addr = pos_q;
          wr_data = rd_rec;
          pos_d   = pos_m1;
        end else begin
          wr_en   = 1'b1;
          wr_addr = pos_q;
          wr_data = new_rec_q;
          count_d = count_q + 1'b1;
          state_d = last_q ? ST_EMIT_RD : ST_IDLE;
        end
      end

      ST_EMIT_RD: begin
        state_d = ST_EMIT_LOAD;
      end

      ST_EMIT_LOAD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_rec_d   = rd_rec;
          out_final_d = (CntW'(emit_idx_q) == count_m1);
          emit_idx_d  = emit_idx_q + 1'b1;
          if (CntW'(emit_idx_q) == count_m1) begin
            count_d = '0;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_EMIT_RD;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      pos_q       <= '0;
      emit_idx_q  <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pos_q       <= pos_d;
      emit_idx_q  <= emit_idx_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_rec_q   <= new_rec_d;
    new_ck_q    <= new_ck_d;
    out_rec_q   <= out_rec_d;
    out_final_q <= out_final_d;
  end

  assign out_valid_o       = out_valid_q;
  assign sorted_key_o      = out_rec_q.key;
  assign sorted_capacity_o = out_rec_q.capacity;
  assign sorted_open_o     = out_rec_q.open_flag;
  assign final_result_o    = out_final_q;

endmodule

[tb/sv/record_sort_checker.sv]
`timescale 1ns / 100ps

module record_sort_checker #(
  parameter int unsigned MAX_RECORDS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic [ris_pkg::KeyW-1:0] sort_key_i,
  input  logic [ris_pkg::CapW-1:0] payload_capacity_i,
  input  logic                     open_flag_i,
  input  logic                     end_of_set_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic [ris_pkg::KeyW-1:0] sorted_key_i,
  input  logic [ris_pkg::CapW-1:0] sorted_capacity_i,
  input  logic                     sorted_open_i,
  input  logic                     final_result_i,
  output int                       error_count_o,
  output int                       pending_count_o,
  output int                       checked_count_o
);
  import ris_pkg::*;

  typedef struct packed {
    record_t rec;
    logic    last;
  } sorted_entry_t;

  record_t       sorted_store [MAX_RECORDS];
  int            stored_count = 0;
  sorted_entry_t expected_sorted [$];
  sorted_entry_t observed;
  int            errors = 0;
  int            checked = 0;

  // c-string order: everything from the first zero byte on is ignored
  function automatic logic [KeyW-1:0] string_rank(input logic [KeyW-1:0] k);
    logic [KeyW-1:0] r;
    logic            ended;
    r = '0;
    ended = 1'b0;
    for (int b = 2; b >= 0; b--) begin
      if (k[b*8 +: 8] == 8'h00) ended = 1'b1;
      if (!ended) r[b*8 +: 8] = k[b*8 +: 8];
    end
    return r;
  endfunction

  // stable insertion; a full store drops the record but still flushes on end of set
  task automatic file_record(input record_t rec, input logic eos);
    int pos;
    sorted_entry_t e;
    if (stored_count < MAX_RECORDS) begin
      pos = stored_count;
      while (pos > 0 && string_rank(sorted_store[pos-1].key) > string_rank(rec.key)) begin
        sorted_store[pos] = sorted_store[pos-1];
        pos--;
      end
      sorted_store[pos] = rec;
      stored_count++;
    end
    if (eos) begin
      for (int i = 0; i < stored_count; i++) begin
        e.rec = sorted_store[i];
        e.last = (i == stored_count - 1);
        expected_sorted.push_back(e);
      end
      stored_count = 0;
    end
  endtask

  task automatic check_result(input sorted_entry_t got);
    sorted_entry_t want;
    if (expected_sorted.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: unexpected result key %06h cap %08h open %0b final %0b", $realtime,
                 got.rec.key, got.rec.capacity, got.rec.open_flag, got.last);
    end else begin
      want = expected_sorted.pop_front();
      checked++;
      if (want.rec.key !== got.rec.key || want.rec.capacity !== got.rec.capacity ||
          want.rec.open_flag !== got.rec.open_flag || want.last !== got.last) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: mismatch on result %0d", $realtime, checked);
          $display("  expected key %06h cap %08h open %0b final %0b",
                   want.rec.key, want.rec.capacity, want.rec.open_flag, want.last);
          $display("  actual   key %06h cap %08h open %0b final %0b",
                   got.rec.key, got.rec.capacity, got.rec.open_flag, got.last);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_count = 0;
      expected_sorted.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        observed = {sorted_key_i, sorted_capacity_i, sorted_open_i, final_result_i};
        check_result(observed);
      end
      if (in_valid_i && !in_stall_i)
        file_record({sort_key_i, payload_capacity_i, open_flag_i}, end_of_set_i);
    end
    error_count_o <= errors;
    pending_count_o <= expected_sorted.size();
    checked_count_o <= checked;
  end

endmodule

[tb/sv/tb_record_insertion_sorter_unit.sv]
`timescale 1ns / 100ps

module tb_record_insertion_sorter_unit;
  import ris_pkg::*;

  localparam int unsigned MaxRecords = 64;
  localparam int WatchdogLimit = 3000;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic [KeyW-1:0] sort_key = '0;
  logic [CapW-1:0] payload_capacity = '0;
  logic            open_flag = 1'b0;
  logic            end_of_set = 1'b0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [KeyW-1:0] sorted_key;
  logic [CapW-1:0] sorted_capacity;
  logic            sorted_open;
  logic            final_result;

  logic calm = 1'b0;
  int   mismatches;
  int   pending_results;
  int   results_checked;
  int   records_sent = 0;
  int   sets_sent = 0;
  int   records_dropped = 0;
  int   idle_cycles = 0;

  record_insertion_sorter_unit #(
    .MAX_RECORDS(MaxRecords)
  ) DUT (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .sort_key_i        (sort_key),
    .payload_capacity_i(payload_capacity),
    .open_flag_i       (open_flag),
    .end_of_set_i      (end_of_set),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .sorted_key_o      (sorted_key),
    .sorted_capacity_o (sorted_capacity),
    .sorted_open_o     (sorted_open),
    .final_result_o    (final_result)
  );

  record_sort_checker #(
    .MAX_RECORDS(MaxRecords)
  ) u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .sort_key_i        (sort_key),
    .payload_capacity_i(payload_capacity),
    .open_flag_i       (open_flag),
    .end_of_set_i      (end_of_set),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .sorted_key_i      (sorted_key),
    .sorted_capacity_i (sorted_capacity),
    .sorted_open_i     (sorted_open),
    .final_result_i    (final_result),
    .error_count_o     (mismatches),
    .pending_count_o   (pending_results),
    .checked_count_o   (results_checked)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 35);
  end

  // watchdog on cycles without any item moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("timeout: nothing moved for %0d cycles", WatchdogLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic logic [7:0] key_char();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'h41;
      2: return 8'h42;
      default: return 8'hFF;
    endcase
  endfunction

  function automatic logic [KeyW-1:0] rand_key();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 3))
      0: return r[KeyW-1:0];
      // narrow alphabet gives equal keys and zero-padded short keys
      1, 2: return {key_char(), key_char(), key_char()};
      default: return {$urandom_range(0, 1) ? 8'h00 : r[23:16],
                       $urandom_range(0, 1) ? 8'h00 : r[15:8],
                       $urandom_range(0, 1) ? 8'h00 : r[7:0]};
    endcase
  endfunction

  function automatic logic [CapW-1:0] rand_capacity();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return r[CapW-1:0];
    endcase
  endfunction

  task automatic send_record(input logic [KeyW-1:0] k, input logic [CapW-1:0] c,
                             input logic o, input logic eos);
    if (!calm) begin
      while ($urandom_range(0, 99) < 35) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    sort_key <= k;
    payload_capacity <= c;
    open_flag <= o;
    end_of_set <= eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    records_sent++;
    if (eos) sets_sent++;
  endtask

  // hold the sender off until every sorted record has come back
  task automatic drain_outputs();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  task automatic run_set(input int count);
    for (int j = 0; j < count; j++)
      send_record(rand_key(), rand_capacity(), 1'($urandom_range(0, 1)), j == count - 1);
    if (count > MaxRecords) records_dropped += count - MaxRecords;
  endtask

  initial begin
    logic [KeyW-1:0] mixed_keys [12];
    logic [CapW-1:0] cap;
    int              set_no;
    int              size;
    mixed_keys = '{24'h414243, 24'h410000, 24'h41005A, 24'h00FFFF, 24'h000000, 24'h414243,
                   24'h414200, 24'h4142FF, 24'hFFFFFF, 24'h80FFFF, 24'h7F0000, 24'h410000};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // single record set at the field maxima
    send_record(24'hFFFFFF, 31'h7FFFFFFF, 1'b1, 1'b1);
    // short keys, bytes after a zero byte, duplicates, top-bit characters
    for (int j = 0; j < 12; j++) begin
      cap = (j % 3 == 0) ? '0 : (j % 3 == 1) ? '1 : rand_capacity();
      send_record(mixed_keys[j], cap, j[0], j == 11);
    end
    // descending keys shift the whole store on every insert
    for (int j = 6; j >= 1; j--)
      send_record({8'h40 + 8'(j), 16'h4242}, 31'(j), 1'b0, j == 1);
    drain_outputs();

    set_no = 0;
    while (records_sent < 150) begin
      calm <= (set_no >= 4 && set_no <= 7);
      if (set_no == 3)
        size = MaxRecords + 2;  // fills the store, then drops a plain and a closing record
      else if ($urandom_range(0, 5) == 0)
        size = $urandom_range(11, 30);
      else
        size = $urandom_range(1, 10);
      run_set(size);
      if ($urandom_range(0, 3) == 0) drain_outputs();
      set_no++;
    end
    calm <= 1'b0;
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (2 * MaxRecords + 20) @(posedge clk);

    $display("sent %0d records in %0d sets, %0d dropped on a full store",
             records_sent, sets_sent, records_dropped);
    $display("checked %0d sorted records, %0d mismatches, %0d still outstanding",
             results_checked, mismatches, pending_results);
    if (mismatches == 0 && pending_results == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
